[sv/rsfe_pkg.sv]
package rsfe_pkg;

    localparam int MAX_FEATURES = 32;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    localparam logic [31:0] SAMPLE_MASK_RST = 32'd127;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [63:0] SEED_A  = 64'd922;
    localparam logic [63:0] SEED_B  = 64'd314159;
    localparam logic [63:0] SF_MIX  = 64'h9e37_79b9_7f4a_7c15;

    typedef logic [31:0] t_coef_tab [MAX_FEATURES];

    localparam logic [31:0] GEAR_TAB [32] = '{
        32'h5C95C078, 32'h22408989, 32'h2D48A214, 32'h12842087,
        32'h530F8AFB, 32'h474536B9, 32'h2963B4F1, 32'h44CB738B,
        32'h4EA7403D, 32'h4D606B6E, 32'h074EC5D3, 32'h3AF39D18,
        32'h726003CA, 32'h37A62A74, 32'h51A2F58E, 32'h7506358E,
        32'h5D4AB128, 32'h4D4AE17B, 32'h41E85924, 32'h470C36F7,
        32'h4741CBE1, 32'h01BB7F30, 32'h617C1DE3, 32'h2B0C3A1F,
        32'h50C48F73, 32'h21A82D37, 32'h6095ACE0, 32'h419167A0,
        32'h3CAF49B0, 32'h40CEA62D, 32'h66BC1C66, 32'h545E1DAD
    };

    // elaboration-time LCG, one step per feature slot
    function automatic t_coef_tab build_coef(input logic [63:0] seed, input logic odd_bit);
        t_coef_tab   tab;
        logic [63:0] s;
        s = seed;
        for (int f = 0; f < MAX_FEATURES; f++) begin
            s = s * LCG_MUL + LCG_ADD;
            tab[f] = {1'b0, s[63:33]} | {31'b0, odd_bit};
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_A = build_coef(SEED_A, 1'b1);
    localparam t_coef_tab COEF_B = build_coef(SEED_B, 1'b0);

    typedef struct packed {
        logic [31:0] hash;
        logic        samp;
        logic        last;
    } t_evt;

    typedef struct packed {
        logic push;
        t_evt evt;
    } t_qwr;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_qrd;

endpackage

[sv/rsfe_if.sv]
interface rsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface rsfe_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] super_feature;
    logic [1:0]  group_index;
    logic        group_last;

    modport source (output valid, output super_feature, output group_index,
                    output group_last, input ready);
    modport sink (input valid, input super_feature, input group_index,
                  input group_last, output ready);
endinterface

interface rsfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/rsfe_front.sv]
module rsfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rsfe_in_if.sink         i_byte,
    rsfe_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output rsfe_pkg::t_qwr  o_qwr
);
    import rsfe_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] r_mask;
    logic [31:0] hash_upd;
    logic        hit;
    logic        take;

    assign i_byte.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign take         = i_byte.valid && i_byte.ready;

    assign hash_upd = {1'b0, r_hash[31:1]} + GEAR_TAB[i_byte.data_byte[4:0]];
    assign hit      = (hash_upd & r_mask) == 32'd0;

    assign o_qwr.push     = take && (hit || i_byte.chunk_end);
    assign o_qwr.evt.hash = hash_upd;
    assign o_qwr.evt.samp = hit;
    assign o_qwr.evt.last = i_byte.chunk_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
            r_mask <= SAMPLE_MASK_RST;
        end else begin
            if (take) begin
                r_hash <= i_byte.chunk_end ? 32'd0 : hash_upd;
            end
            if (i_cfg.valid) begin
                r_mask <= i_cfg.data;
            end
        end
    end

endmodule

[sv/rsfe_queue.sv]
module rsfe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsfe_pkg::t_qwr  i_qwr,
    input  logic            i_pop,
    output logic            o_full,
    output rsfe_pkg::t_qrd  o_qrd
);
    import rsfe_pkg::*;

    t_evt         r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wp;
    logic [Q_AW:0] r_rp;

    assign o_full      = (r_wp - r_rp) == (Q_AW + 1)'(Q_DEPTH);
    assign o_qrd.valid = r_wp != r_rp;
    assign o_qrd.evt   = r_mem[r_rp[Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_qwr.push) begin
            r_mem[r_wp[Q_AW-1:0]] <= i_qwr.evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_qwr.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

[sv/rsfe_back.sv]
module rsfe_back #(
    parameter int NUM_FEATURES = 12,
    parameter int NUM_SUPER    = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsfe_pkg::t_qrd  i_qrd,
    output logic            o_pop,
    rsfe_out_if.source      o_sf
);
    import rsfe_pkg::*;

    localparam int PER = NUM_FEATURES / NUM_SUPER;
    localparam int FW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int GW  = (NUM_SUPER > 1) ? $clog2(NUM_SUPER) : 1;
    localparam int IW  = (PER > 1) ? $clog2(PER) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SMUL = 8'b0000_0010,
        S_SCMP = 8'b0000_0100,
        S_F0   = 8'b0000_1000,
        S_F1   = 8'b0001_0000,
        S_F2   = 8'b0010_0000,
        S_F3   = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_bstate;

    t_bstate     r_state;
    logic [FW-1:0] r_feat;
    logic [GW-1:0] r_grp;
    logic [IW-1:0] r_item;
    logic [63:0] r_feats [NUM_FEATURES];
    logic [63:0] r_prod;
    logic [63:0] r_part;
    logic [63:0] r_acc;
    logic        r_ovalid;
    logic [63:0] r_osf;
    logic [1:0]  r_ogrp;
    logic        r_olast;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] cur;
    logic [63:0] cand;
    logic [31:0] hi_sum;
    logic        out_free;
    logic        emit;
    logic        grp_last;

    assign cur      = r_feats[r_feat];
    assign cand     = r_prod + {32'd0, COEF_B[5'(r_feat)]};
    assign hi_sum   = r_part[63:32] + r_prod[31:0];
    assign out_free = !r_ovalid || o_sf.ready;
    assign grp_last = r_grp == GW'(NUM_SUPER - 1);
    assign emit     = (r_state == S_EMIT) && out_free;
    assign o_pop    = (emit && grp_last) ||
                      ((r_state == S_SCMP) && (r_feat == FW'(NUM_FEATURES - 1)) &&
                       !i_qrd.evt.last);

    assign o_sf.valid         = r_ovalid;
    assign o_sf.super_feature = r_osf;
    assign o_sf.group_index   = r_ogrp;
    assign o_sf.group_last    = r_olast;

    // shared 32x32 multiplier
    always_comb begin
        case (r_state)
            S_SMUL: begin
                mul_a = i_qrd.evt.hash;
                mul_b = COEF_A[5'(r_feat)];
            end
            S_F0: begin
                mul_a = cur[31:0];
                mul_b = SF_MIX[31:0];
            end
            S_F1: begin
                mul_a = cur[63:32];
                mul_b = SF_MIX[31:0];
            end
            S_F2: begin
                mul_a = cur[31:0];
                mul_b = SF_MIX[63:32];
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            S_F1: r_part <= r_prod;
            S_F2: r_part[63:32] <= hi_sum;
            default: r_part <= r_part;
        endcase
        if (emit) begin
            r_osf   <= r_acc;
            r_ogrp  <= 2'(r_grp);
            r_olast <= grp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_feat   <= '0;
            r_grp    <= '0;
            r_item   <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
            for (int f = 0; f < NUM_FEATURES; f++) begin
                r_feats[f] <= 64'd0;
            end
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_sf.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_feat <= '0;
                    r_grp  <= '0;
                    r_item <= '0;
                    r_acc  <= '0;
                    if (i_qrd.valid) begin
                        if (i_qrd.evt.samp) begin
                            r_state <= S_SMUL;
                        end else begin
                            r_state <= (PER == 0) ? S_EMIT : S_F0;
                        end
                    end
                end
                S_SMUL: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (cand > cur) begin
                        r_feats[r_feat] <= cand;
                    end
                    if (r_feat == FW'(NUM_FEATURES - 1)) begin
                        r_feat <= '0;
                        if (i_qrd.evt.last) begin
                            r_state <= (PER == 0) ? S_EMIT : S_F0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_feat  <= r_feat + 1'b1;
                        r_state <= S_SMUL;
                    end
                end
                S_F0: r_state <= S_F1;
                S_F1: r_state <= S_F2;
                S_F2: r_state <= S_F3;
                S_F3: begin
                    r_acc  <= r_acc ^ {hi_sum, r_part[31:0]};
                    r_feat <= r_feat + 1'b1;
                    if (r_item == IW'(PER - 1)) begin
                        r_item  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_item  <= r_item + 1'b1;
                        r_state <= S_F0;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_acc <= '0;
                        if (grp_last) begin
                            for (int f = 0; f < NUM_FEATURES; f++) begin
                                r_feats[f] <= 64'd0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_grp   <= r_grp + 1'b1;
                            r_state <= (PER == 0) ? S_EMIT : S_F0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/resemblance_super_feature_extractor.sv]
// Chunk bytes enter on i_byte at one word per clock; the front hashes each byte
// in the cycle it is accepted and queues only sampled bytes and chunk ends, so
// i_byte stalls only when the 4-entry queue is full. The back works one queued
// entry at a time on a single shared 32x32 multiplier: a sampled byte runs
// S_SMUL then S_SCMP for each feature; a chunk end, after those if sampled,
// runs S_F0 to S_F3 for each feature of a group, then S_EMIT, which waits
// while o_sf is held off. It emits one o_sf word per group, the last one
// flagged group_last. i_cfg writes sample_mask (reset 127) and is always ready.
module resemblance_super_feature_extractor #(
    parameter int NUM_FEATURES = 12,
    parameter int NUM_SUPER    = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsfe_in_if.sink     i_byte,
    rsfe_cfg_if.sink    i_cfg,
    rsfe_out_if.source  o_sf
);
    import rsfe_pkg::*;

    t_qwr qwr;
    t_qrd qrd;
    logic q_full;
    logic pop;

    rsfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_qwr    (qwr)
    );

    rsfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_qrd   (qrd)
    );

    rsfe_back #(
        .NUM_FEATURES (NUM_FEATURES),
        .NUM_SUPER    (NUM_SUPER)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qrd   (qrd),
        .o_pop   (pop),
        .o_sf    (o_sf)
    );

endmodule

[sv/rsfe_checker.sv]
module rsfe_checker #(
    parameter int NUM_SUPER = 3
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_end,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_grp,
    input logic       i_out_last
);
    localparam int GW = (NUM_SUPER > 1) ? $clog2(NUM_SUPER) : 1;

    logic [GW-1:0] r_cnt;
    logic [7:0]    r_pend;
    logic          end_acc;
    logic          last_acc;

    assign end_acc  = i_in_valid && i_in_ready && i_in_end;
    assign last_acc = i_out_valid && i_out_ready && i_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                r_cnt <= i_out_last ? '0 : r_cnt + 1'b1;
            end
            r_pend <= r_pend + {7'd0, end_acc} - {7'd0, last_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_grp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_grp == 2'(r_cnt)) &&
                        (i_out_last == (r_cnt == GW'(NUM_SUPER - 1))))
        else $error("group index or last flag out of order");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 8'd0)
        else $error("output word without a pending chunk end");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind resemblance_super_feature_extractor rsfe_checker #(
    .NUM_SUPER (NUM_SUPER)
) u_rsfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_end    (i_byte.chunk_end),
    .i_out_valid (o_sf.valid),
    .i_out_ready (o_sf.ready),
    .i_out_grp   (o_sf.group_index),
    .i_out_last  (o_sf.group_last)
);
